@@ design/bit_quad_region_counter_top_assert.svh @@
// Assertion macros for the bit-quad region counter.
// Used by the top level; no other dependencies.
`ifndef BIT_QUAD_REGION_COUNTER_TOP_ASSERT_SVH
`define BIT_QUAD_REGION_COUNTER_TOP_ASSERT_SVH

// hold a property at every clock edge outside reset
`define BQRC_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bqrc: invariant violated");

// demand a consequence in the cycle after a trigger
`define BQRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqrc: expected follow-up missing");

`endif

@@ design/bqrc_pkg.sv @@
// Shared types, constants and window classification for the bit-quad region counter.
// No dependencies.
`default_nettype none

package bqrc_pkg;

   localparam int PIXEL_W   = 8;
   localparam logic [PIXEL_W-1:0] PIXEL_SET = 8'hFF;
   localparam int CFG_W     = 13;
   localparam int ROW_W     = 12;
   localparam int MAX_HEIGHT = 4096;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam int COUNT_W = 25;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1FFFFFF;
   localparam int INC_W   = 3;
   localparam int RESULT_W = 25;
   localparam int DIFF_W  = 28;
   localparam logic signed [DIFF_W-1:0] RESULT_HI = 28'sd16777215;
   localparam logic signed [DIFF_W-1:0] RESULT_LO = -28'sd16777216;

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = 3;
   localparam int FILL_W    = 4;

   typedef struct packed {
      logic pix_bit;
      logic last_col;
      logic last_row;
      logic row0;
   } pix_ctl_type;

   typedef struct packed {
      logic [ROW_W-1:0] hlast;
      logic             restart;
   } frame_ctl_type;

   typedef struct packed {
      logic one;
      logic three;
      logic diag;
   } win_class_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] n1;
      logic [COUNT_W-1:0] n3;
      logic [COUNT_W-1:0] nd;
   } tally_out_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic              x_valid;
   } res_stat_type;

   // a = top-left, b = top-right, c = bottom-left, d = bottom-right
   function automatic win_class_type classify(input logic a, input logic b,
                                              input logic c, input logic d);
      win_class_type   cls;
      logic [2:0]      n;
      n = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      cls.one   = (n == 3'd1);
      cls.three = (n == 3'd3);
      cls.diag  = (n == 3'd2) && (a == d);
      return cls;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] n,
                                                  input logic [INC_W-1:0] inc);
      logic [COUNT_W:0] sum;
      sum = {1'b0, n} + {{(COUNT_W+1-INC_W){1'b0}}, inc};
      return (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/bqrc_req_if.sv @@
// Pixel input channel: valid/ready handshake with an 8-bit pixel payload.
// No dependencies.
`default_nettype none

interface bqrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ design/bqrc_rsp_if.sv @@
// Result channel: valid/ready handshake with a signed 25-bit region count.
// No dependencies.
`default_nettype none

interface bqrc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [24:0] region_count;

   modport source (output valid, output region_count, input ready);
   modport sink   (input valid, input region_count, output ready);
endinterface

`default_nettype wire

@@ design/bqrc_csr.sv @@
// APB register file: frame width and height, restart pulse on every write.
// Depends on bqrc_pkg.
`default_nettype none

module bqrc_csr
   import bqrc_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_W-1:0]    paddr,
   input  wire logic [DATA_W-1:0]    pwdata,
   output logic      [DATA_W-1:0]    prdata,
   output logic                      pready,
   output logic [$clog2(MAX_WIDTH)-1:0] wlast,
   output frame_ctl_type             frame_ctl
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             wr_en;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FRAME_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:  prdata = {{(DATA_W-CFG_W){1'b0}}, width_ff};
         REG_FRAME_HEIGHT: prdata = {{(DATA_W-CFG_W){1'b0}}, height_ff};
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (width_ff == '0) begin
         wlast = '0;
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         wlast = CW'(MAX_WIDTH - 1);
      end else begin
         wlast = CW'(width_ff - 13'd1);
      end
   end

   always_comb begin
      if (height_ff == '0) begin
         frame_ctl.hlast = '0;
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         frame_ctl.hlast = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         frame_ctl.hlast = ROW_W'(height_ff - 13'd1);
      end
      frame_ctl.restart = wr_en;
   end

endmodule

`default_nettype wire

@@ design/bqrc_line_buf.sv @@
// One-bit line buffer holding the previous row, with write-to-read forwarding.
// No dependencies.
`default_nettype none

module bqrc_line_buf
#(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  wire logic                         wr_bit,
   output logic                              rd_bit
);

   logic mem [MAX_WIDTH];
   logic rd_data_ff;
   logic fwd_ff, fwd_in;
   logic fwd_bit_ff;

   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_bit_ff <= wr_bit;
      end
   end

   assign rd_bit = fwd_ff ? fwd_bit_ff : rd_data_ff;

endmodule

`default_nettype wire

@@ design/bqrc_tally.sv @@
// Window classifier and saturating bit-quad counters; snapshots counts at frame end.
// Depends on bqrc_pkg.
`default_nettype none

module bqrc_tally
   import bqrc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          restart,
   input  wire logic          valid,
   input  wire pix_ctl_type   ctl,
   input  wire logic          up_raw,
   output tally_out_type      tally_out
);

   logic [COUNT_W-1:0] n1_ff, n3_ff, nd_ff;
   logic [COUNT_W-1:0] n1_in, n3_in, nd_in;
   logic               left_ff, ul_ff;
   logic               done_ff;
   logic [COUNT_W-1:0] fin_n1_ff, fin_n3_ff, fin_nd_ff;
   logic               up;
   logic               frame_end;
   win_class_type      w0, w1, w2, w3;
   logic [INC_W-1:0]   inc1, inc3, incd;

   assign up        = ctl.row0 ? 1'b1 : up_raw;
   assign frame_end = ctl.last_col && ctl.last_row;

   always_comb begin
      w0 = classify(ul_ff, up, left_ff, ctl.pix_bit);
      w1 = ctl.last_col ? classify(up, 1'b1, ctl.pix_bit, 1'b1) : '0;
      w2 = ctl.last_row ? classify(left_ff, ctl.pix_bit, 1'b1, 1'b1) : '0;
      w3 = frame_end    ? classify(ctl.pix_bit, 1'b1, 1'b1, 1'b1) : '0;
      inc1 = INC_W'(w0.one) + INC_W'(w1.one) + INC_W'(w2.one) + INC_W'(w3.one);
      inc3 = INC_W'(w0.three) + INC_W'(w1.three) + INC_W'(w2.three)
             + INC_W'(w3.three);
      incd = INC_W'(w0.diag) + INC_W'(w1.diag) + INC_W'(w2.diag) + INC_W'(w3.diag);
      n1_in = sat_add(n1_ff, inc1);
      n3_in = sat_add(n3_ff, inc3);
      nd_in = sat_add(nd_ff, incd);
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         n1_ff   <= '0;
         n3_ff   <= '0;
         nd_ff   <= '0;
         left_ff <= 1'b1;
         ul_ff   <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         done_ff <= valid && frame_end;
         if (valid) begin
            if (frame_end) begin
               n1_ff <= '0;
               n3_ff <= '0;
               nd_ff <= '0;
            end else begin
               n1_ff <= n1_in;
               n3_ff <= n3_in;
               nd_ff <= nd_in;
            end
            if (ctl.last_col) begin
               left_ff <= 1'b1;
               ul_ff   <= 1'b1;
            end else begin
               left_ff <= ctl.pix_bit;
               ul_ff   <= up;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (valid && frame_end) begin
         fin_n1_ff <= n1_in;
         fin_n3_ff <= n3_in;
         fin_nd_ff <= nd_in;
      end
   end

   assign tally_out.done = done_ff;
   assign tally_out.n1   = fin_n1_ff;
   assign tally_out.n3   = fin_n3_ff;
   assign tally_out.nd   = fin_nd_ff;

endmodule

`default_nettype wire

@@ design/bqrc_result.sv @@
// Region count arithmetic (difference, ceiling divide by four, clamp) and result queue.
// Depends on bqrc_pkg and bqrc_rsp_if.
`default_nettype none

module bqrc_result
   import bqrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire tally_out_type tally_out,
   bqrc_rsp_if.source       rsp_chan,
   output res_stat_type     res_stat
);

   logic signed [DIFF_W-1:0]   x_ff, x_in;
   logic                       x_valid_ff;
   logic signed [DIFF_W-1:0]   q;
   logic [RESULT_W-1:0]        q_sat;
   logic [RESULT_W-1:0]        queue_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic                       push, pop;

   // ceil(d / 4) == floor((d + 3) / 4) for any integer d
   assign x_in = $signed({3'b000, tally_out.n3}) - $signed({3'b000, tally_out.n1})
                 - $signed({2'b00, tally_out.nd, 1'b0}) + 28'sd3;

   always_ff @(posedge clock) begin
      if (tally_out.done) begin
         x_ff <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= tally_out.done;
      end
   end

   assign q = x_ff >>> 2;

   always_comb begin
      if (q > RESULT_HI) begin
         q_sat = RESULT_W'(RESULT_HI);
      end else if (q < RESULT_LO) begin
         q_sat = RESULT_W'(RESULT_LO);
      end else begin
         q_sat = q[RESULT_W-1:0];
      end
   end

   assign push = x_valid_ff;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= q_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + FILL_W'(push) - FILL_W'(pop);
      end
   end

   assign rsp_chan.valid        = (fill_ff != '0);
   assign rsp_chan.region_count = $signed(queue_mem[rd_ptr_ff]);

   assign res_stat.fill    = fill_ff;
   assign res_stat.x_valid = x_valid_ff;

endmodule

`default_nettype wire

@@ design/bit_quad_region_counter_top.sv @@
// Bit-quad region counter: top level with raster position tracking and stage wiring.
// Depends on bqrc_pkg, bqrc_req_if, bqrc_rsp_if, bqrc_csr, bqrc_line_buf,
// bqrc_tally, bqrc_result and bit_quad_region_counter_top_assert.svh.
//
// Usage:
//   req_chan carries one gray pixel per beat in raster order; a pixel counts
//   as set only at 255. After the last pixel of a frame (frame_width x
//   frame_height, set over the APB port) one beat on rsp_chan carries the
//   signed region count. Any register write restarts the frame.
//   Throughput: one pixel per cycle while ready is high. The line buffer
//   is read on the accept cycle and written back in the following cycle;
//   a one-pixel-wide frame reuses the entry just written through a bypass.
//   The result beat is offered once the last accepted pixel has passed
//   its stages (classify and count, difference, clamp and queue).
//   Results wait in an 8-entry queue; when the receiver stalls, req_chan
//   keeps taking pixels until the queue plus results still in flight would
//   fill it, then drops ready.
//   Reset: width 640, height 480, position at the frame start, counts zero,
//   queue empty. The line buffer needs no clearing: the first row uses the
//   top border instead.
`default_nettype none

`include "bit_quad_region_counter_top_assert.svh"

module bit_quad_region_counter_top
   import bqrc_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   bqrc_req_if.sink               req_chan,
   bqrc_rsp_if.source             rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CW-1:0]    wlast;
   frame_ctl_type    frame_ctl;
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept;
   pix_ctl_type      a_ctl;
   logic             b_valid_ff;
   pix_ctl_type      b_ctl_ff;
   logic [CW-1:0]    b_addr_ff;
   logic             up_raw;
   tally_out_type    tally_out;
   res_stat_type     res_stat;
   logic [FILL_W:0]  occupancy;

   bqrc_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .wlast     (wlast),
      .frame_ctl (frame_ctl)
   );

   assign occupancy = {1'b0, res_stat.fill}
                      + (FILL_W+1)'(b_valid_ff && b_ctl_ff.last_col && b_ctl_ff.last_row)
                      + (FILL_W+1)'(tally_out.done)
                      + (FILL_W+1)'(res_stat.x_valid);

   assign req_chan.ready = (occupancy < (FILL_W+1)'(RSP_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      a_ctl.pix_bit  = (req_chan.pixel == PIXEL_SET);
      a_ctl.last_col = (col_ff == wlast);
      a_ctl.last_row = (row_ff == frame_ctl.hlast);
      a_ctl.row0     = (row_ff == '0);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (a_ctl.last_col) begin
            col_in = '0;
            row_in = a_ctl.last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || frame_ctl.restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_ctl_ff  <= a_ctl;
         b_addr_ff <= col_ff;
      end
   end

   bqrc_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_bit  (b_ctl_ff.pix_bit),
      .rd_bit  (up_raw)
   );

   bqrc_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .restart   (frame_ctl.restart),
      .valid     (b_valid_ff),
      .ctl       (b_ctl_ff),
      .up_raw    (up_raw),
      .tally_out (tally_out)
   );

   bqrc_result u_result (
      .clock     (clock),
      .reset     (reset),
      .tally_out (tally_out),
      .rsp_chan  (rsp_chan),
      .res_stat  (res_stat)
   );

   `BQRC_ASSERT_ALWAYS(a_queue_bound, clock, reset, res_stat.fill <= FILL_W'(RSP_DEPTH))
   `BQRC_ASSERT_NEXT(a_accept_to_tally, clock, reset, accept, b_valid_ff)
   `BQRC_ASSERT_NEXT(a_done_to_result, clock, reset, tally_out.done, res_stat.x_valid)

endmodule

`default_nettype wire

@@ test/tb_bit_quad_region_counter_top.sv @@
// Testbench for bit_quad_region_counter_top: streams thresholded frames and checks each
// region count against a cycle-free bit-quad predictor kept alongside the stimulus.
// Depends on bqrc_pkg, bqrc_req_if, bqrc_rsp_if and the design top level.
module tb_bit_quad_region_counter_top;
   import bqrc_pkg::*;

   localparam int LINE_MAX      = 4096;
   localparam int LINE_AW       = $clog2(LINE_MAX);
   localparam int SETTLE        = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SHOWN_FAILS   = 10;
   localparam int PHASE_PIXELS  = 110;
   localparam int PHASE_FRAMES  = 8;
   localparam int PART_PIXELS   = 50;
   localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
   localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};
   localparam logic [CFG_W-1:0]  CFG_ALL_ONES = '1;
   localparam logic [COUNT_W-1:0] TALLY_TOP   = '1;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   bqrc_req_if req_bus ();
   bqrc_rsp_if rsp_bus ();

   bit_quad_region_counter_top #(
      .MAX_WIDTH(LINE_MAX)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state
   logic               line_bits [0:LINE_MAX-1];
   logic               west_bit;
   logic               northwest_bit;
   int unsigned        col_pos;
   int unsigned        row_pos;
   logic [COUNT_W-1:0] isolated_cnt;
   logic [COUNT_W-1:0] notch_cnt;
   logic [COUNT_W-1:0] cross_cnt;
   logic [CFG_W-1:0]   reg_width;
   logic [CFG_W-1:0]   reg_height;

   logic signed [RESULT_W-1:0] expected_counts [$];
   logic signed [RESULT_W-1:0] wanted;

   int src_idle_pct;
   int sink_stall_pct;
   int hold_left;
   int cycle_count;
   int fail_count;
   int counts_checked;
   int pixels_sent;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void note_failure(input string what, input longint want,
                                        input longint got);
      fail_count++;
      if (fail_count <= SHOWN_FAILS)
         $display("mismatch: %s expected %0d got %0d", what, want, got);
   endfunction

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                             input int unsigned cap);
      if (v == '0)
         return 1;
      if (v > cap)
         return cap;
      return 32'(v);
   endfunction

   function automatic int frame_pixels();
      return clamp_dim(reg_width, LINE_MAX) * clamp_dim(reg_height, MAX_HEIGHT);
   endfunction

   function automatic void bump(ref logic [COUNT_W-1:0] cnt);
      if (cnt != TALLY_TOP)
         cnt = cnt + 1'b1;
   endfunction

   // a top-left, b top-right, c bottom-left, d bottom-right
   function automatic void tally_quad(input logic a, input logic b, input logic c,
                                      input logic d);
      int n;
      n = int'(a) + int'(b) + int'(c) + int'(d);
      if (n == 1)
         bump(isolated_cnt);
      else if (n == 3)
         bump(notch_cnt);
      else if (n == 2 && a == d)
         bump(cross_cnt);
   endfunction

   function automatic void restart_frame();
      west_bit      = 1'b1;
      northwest_bit = 1'b1;
      col_pos       = 0;
      row_pos       = 0;
      isolated_cnt  = '0;
      notch_cnt     = '0;
      cross_cnt     = '0;
   endfunction

   function automatic void step_bit_quads(input logic [PIXEL_W-1:0] value);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic        px;
      logic        up;
      logic        at_right;
      logic        at_bottom;
      longint      diff;
      longint      quot;
      w = clamp_dim(reg_width, LINE_MAX);
      h = clamp_dim(reg_height, MAX_HEIGHT);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      px = (value == PIXEL_SET);
      at_right  = (c == w - 1);
      at_bottom = (r == h - 1);
      up = (r == 0) ? 1'b1 : line_bits[LINE_AW'(c)];
      tally_quad(northwest_bit, up, west_bit, px);
      if (at_right)
         tally_quad(up, 1'b1, px, 1'b1);
      if (at_bottom) begin
         tally_quad(west_bit, px, 1'b1, 1'b1);
         if (at_right)
            tally_quad(px, 1'b1, 1'b1, 1'b1);
      end
      line_bits[LINE_AW'(c)] = px;
      northwest_bit = up;
      west_bit      = px;
      if (!at_right) begin
         col_pos = c + 1;
         row_pos = r;
      end else begin
         col_pos       = 0;
         west_bit      = 1'b1;
         northwest_bit = 1'b1;
         if (!at_bottom) begin
            row_pos = r + 1;
         end else begin
            diff = longint'(notch_cnt) - longint'(isolated_cnt) - 2 * longint'(cross_cnt);
            quot = (diff >= 0) ? (diff + 3) / 4 : -((-diff) / 4);
            if (quot > 16777215)
               quot = 16777215;
            if (quot < -16777216)
               quot = -16777216;
            expected_counts.push_back(quot[RESULT_W-1:0]);
            restart_frame();
         end
      end
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      if ($urandom_range(9) < 6)
         return PIXEL_SET;
      return PIXEL_W'($urandom_range(254, 0));
   endfunction

   function automatic logic [CFG_W-1:0] pick_dim(input int unsigned big);
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         9: begin
            return CFG_W'($urandom_range(big, 6));
         end
         default: begin
            return CFG_W'($urandom_range(5, 1));
         end
      endcase
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      step_bit_quads(value);
      pixels_sent++;
   endtask

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++)
         send_pixel(pick_pixel());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
      logic [DATA_W-1:0] noise;
      noise = $urandom();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {noise[DATA_W-1:CFG_W], value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (addr == WIDTH_ADDR)
         reg_width = value;
      else
         reg_height = value;
      restart_frame();
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
      logic [DATA_W-1:0] got;
      csr_read(addr, got);
      if (got !== DATA_W'(want))
         note_failure(addr == WIDTH_ADDR ? "frame_width read" : "frame_height read",
                      longint'(want), longint'(got));
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      drain_results();
      csr_write(WIDTH_ADDR, w);
      csr_write(HEIGHT_ADDR, h);
   endtask

   task automatic test_register_access();
      check_reg(WIDTH_ADDR, WIDTH_RESET);
      check_reg(HEIGHT_ADDR, HEIGHT_RESET);
      csr_write(WIDTH_ADDR, CFG_ALL_ONES);
      check_reg(WIDTH_ADDR, CFG_ALL_ONES);
      csr_write(HEIGHT_ADDR, '0);
      check_reg(HEIGHT_ADDR, '0);
      csr_write(HEIGHT_ADDR, CFG_W'(LINE_MAX));
      check_reg(HEIGHT_ADDR, CFG_W'(LINE_MAX));
      csr_write(WIDTH_ADDR, CFG_W'(1));
      check_reg(WIDTH_ADDR, CFG_W'(1));
   endtask

   task automatic test_directed_frames();
      set_frame('0, '0);
      send_pixel(PIXEL_SET);
      send_pixel(8'h00);
      send_pixel(8'hFE);
      send_pixel(8'h7F);
      set_frame(CFG_W'(2), CFG_W'(2));
      send_pixel(PIXEL_SET);
      send_pixel(8'h00);
      send_pixel(8'h00);
      send_pixel(PIXEL_SET);
      send_pixel(8'h00);
      send_pixel(PIXEL_SET);
      send_pixel(PIXEL_SET);
      send_pixel(8'h00);
      set_frame(CFG_W'(3), CFG_W'(3));
      for (int i = 0; i < 9; i++)
         send_pixel(i == 4 ? 8'h80 : PIXEL_SET);
   endtask

   task automatic test_restart_on_write();
      set_frame(CFG_W'(3), CFG_W'(3));
      send_random(5);
      drain_results();
      csr_write(WIDTH_ADDR, CFG_W'(4));
      send_random(12);
      send_random(3);
      drain_results();
      csr_write(HEIGHT_ADDR, CFG_W'(2));
      send_random(8);
   endtask

   task automatic test_extreme_sizes();
      // leave the oversized frames unfinished; the next write restarts them
      set_frame(CFG_ALL_ONES, CFG_W'(2));
      send_random(PART_PIXELS);
      set_frame(CFG_W'(1), CFG_ALL_ONES);
      send_random(PART_PIXELS);
      set_frame(CFG_W'(LINE_MAX), CFG_W'(1));
      send_random(PART_PIXELS);
      set_frame(CFG_W'(24), CFG_W'(3));
      send_random(frame_pixels());
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct);
      int sent;
      int frames;
      int npix;
      sent   = 0;
      frames = 0;
      src_idle_pct   = idle_pct;
      sink_stall_pct = stall_pct;
      while (sent < PHASE_PIXELS || frames < PHASE_FRAMES) begin
         set_frame(pick_dim(24), pick_dim(12));
         npix = frame_pixels();
         // cut some frames short; the next write restarts them
         if (npix > 1 && $urandom_range(7) == 0)
            npix = $urandom_range(npix - 1, 1);
         send_random(npix);
         sent += npix;
         frames++;
      end
   endtask

   task automatic test_output_holdoff();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      set_frame(CFG_W'(1), CFG_W'(1));
      hold_left = HOLD_CYCLES;
      send_random(40);
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_counts.size() == 0) begin
            note_failure("region count beat with none pending", 0,
                         longint'(rsp_bus.region_count));
         end else begin
            wanted = expected_counts.pop_front();
            counts_checked++;
            if (rsp_bus.region_count !== wanted)
               note_failure("region_count", longint'(wanted),
                            longint'(rsp_bus.region_count));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d region counts pending", cycle_count,
               expected_counts.size());
      $display("[bit_quad_region_counter_top] ERROR");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.pixel  = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_left      = 0;
      cycle_count    = 0;
      fail_count     = 0;
      counts_checked = 0;
      pixels_sent    = 0;
      for (int i = 0; i < LINE_MAX; i++)
         line_bits[LINE_AW'(i)] = 1'b0;
      reg_width  = WIDTH_RESET;
      reg_height = HEIGHT_RESET;
      restart_frame();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_frames();
      test_restart_on_write();
      test_extreme_sizes();
      test_random_frames(0, 0);
      test_random_frames(85, 0);
      test_random_frames(0, 85);
      test_random_frames(19, 19);
      test_output_holdoff();
      drain_results();

      $display("covered %0d pixels and %0d region counts under open, sparse, stalled",
               pixels_sent, counts_checked);
      $display("and mixed pacing, clamped and restarted frames, %0d-cycle output hold-off",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("[bit_quad_region_counter_top] OK");
      end else begin
         $display("%0d failures in all", fail_count);
         $display("[bit_quad_region_counter_top] ERROR");
      end
      $finish;
   end

endmodule

@@ bit_quad_region_counter_top.f @@
+incdir+design
design/bqrc_pkg.sv
design/bqrc_req_if.sv
design/bqrc_rsp_if.sv
design/bqrc_csr.sv
design/bqrc_line_buf.sv
design/bqrc_tally.sv
design/bqrc_result.sv
design/bit_quad_region_counter_top.sv
test/tb_bit_quad_region_counter_top.sv
